### hdl/dts_pkg.sv
// Package for the depth-first topological sort block.
// Holds default sizes, mode codes and register addresses; no dependencies.
`default_nettype none
package dts_pkg;
   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_MAX_EDGES    = 256;
   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] REG_VCOUNT = 2'd0;
   localparam logic [6:0] VCOUNT_RESET = 7'd64;
endpackage
`default_nettype wire

### hdl/dts_edge_mem.sv
// Edge store of the topological sort block: target and link per edge.
// One write port, a link-only relink port and one registered read port; uses dts_pkg.
`default_nettype none
module dts_edge_mem #(
   parameter int MAX_EDGES = dts_pkg::DEF_MAX_EDGES,
   parameter int VW = 6,
   parameter int EW = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [EW-1:0] wr_addr,
   input  wire logic [VW-1:0] wr_target,
   input  wire logic [EW:0]   wr_link,
   input  wire logic          lk_en,
   input  wire logic [EW-1:0] lk_addr,
   input  wire logic [EW:0]   lk_link,
   input  wire logic [EW-1:0] rd_addr,
   output logic      [VW-1:0] rd_target,
   output logic      [EW:0]   rd_link
);
   import dts_pkg::*;
   logic [VW-1:0] target_mem [MAX_EDGES];
   logic [EW:0]   link_mem [MAX_EDGES];
   always_ff @(posedge clock) begin
      if (wr_en) target_mem[wr_addr] <= wr_target;
      rd_target <= target_mem[rd_addr];
   end
   // Link memory takes either a fresh edge or a tail relink, never both.
   always_ff @(posedge clock) begin
      if (wr_en) link_mem[wr_addr] <= wr_link;
      else if (lk_en) link_mem[lk_addr] <= lk_link;
      rd_link <= link_mem[rd_addr];
   end
endmodule
`default_nettype wire

### hdl/dfs_topological_sort.sv
// Top level of the depth-first topological sort block.
// Uses dts_pkg and dts_edge_mem.
//
// Channel  Direction  Handshake        Contents
// req      in         tvalid/tready    tdata: mode[1:0] from[7:2] to[13:8]
// rsp      out        tvalid/tready    tdata: vertex[5:0]; tlast; tuser: edges_dropped
// csr      in         APB              vertex_count at address 0
//
// An add edge passes through S_ADD1 and S_ADD2; a clear completes in S_IDLE. A run
// first sweeps the per-vertex tables, one vertex at a time through S_SWEEP and
// S_CLR, then walks the graph, each stack step fed by the registered stack,
// cursor and edge memory reads.
// Reset is synchronous and clears control state and the list heads valid bits.
// A result stalled on rsp holds the walk until the transaction completes.
`default_nettype none
module dfs_topological_sort #(
   parameter int MAX_VERTICES = dts_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = dts_pkg::DEF_MAX_EDGES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // mode, from_vertex, to_vertex
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // vertex
   output logic             rsp_tlast,
   output logic             rsp_tuser,   // edges_dropped
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import dts_pkg::*;
   localparam int VW = 6;
   localparam int VI = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int DW = $clog2(MAX_VERTICES + 1);
   localparam logic [EW:0] ENONE = (EW+1)'(MAX_EDGES);
   localparam logic [6:0]  MAXV7 = 7'(MAX_VERTICES);

   localparam logic [3:0] S_IDLE = 4'd0, S_ADD1 = 4'd1, S_ADD2 = 4'd2,
      S_SWEEP = 4'd3, S_START = 4'd4, S_TOP = 4'd5, S_CUR = 4'd6,
      S_EDGE = 4'd7, S_EMIT = 4'd8, S_NEXT = 4'd9, S_CLR = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [6:0] vcount_ff;
   logic [EW:0] fill_ff, fill_in;
   logic drop_ff, drop_in;
   logic [MAX_VERTICES-1:0] head_ok_ff, head_ok_in;
   logic [MAX_VERTICES-1:0] vis_ff, vis_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [6:0] start_ff, start_in;
   logic [VI-1:0] v_ff, v_in;
   logic [EW:0] c_ff, c_in;
   logic [VW-1:0] src_ff, src_in, dst_ff, dst_in;
   logic [EW:0] head_rd_ff, tail_unused;
   logic [VW-1:0] stk_rd_ff;
   logic [VI-1:0] ptr_ff, ptr_in;
   logic out_v_ff, out_v_in;
   logic [VW-1:0] out_vx_ff, out_vx_in;
   logic out_last_ff, out_last_in, out_drop_ff, out_drop_in;

   // Per-vertex memories.
   logic [EW:0]   first_mem [MAX_VERTICES];
   logic [EW-1:0] last_mem [MAX_VERTICES];
   logic [EW:0]   cur_mem [MAX_VERTICES];
   logic [VW-1:0] stack_mem [MAX_VERTICES];
   logic [EW-1:0] last_rd_ff;
   logic [EW:0]   cur_rd_ff;

   logic first_we, last_we, cur_we, stk_we;
   logic [VI-1:0] first_wa, last_wa, cur_wa, stk_wa, vrd_a, stk_ra;
   logic [EW:0] first_wd, cur_wd;
   logic [VW-1:0] stk_wd;
   logic e_we, lk_en;
   logic [EW-1:0] e_ra;
   logic [VW-1:0] e_tgt;
   logic [EW:0] e_link;
   logic [6:0] n_eff;
   logic [6:0] t_ext;

   assign tail_unused = '0;
   assign n_eff = (vcount_ff > MAXV7) ? MAXV7 : vcount_ff;
   assign t_ext = {1'b0, e_tgt};

   always_ff @(posedge clock) begin
      if (first_we) first_mem[first_wa] <= first_wd;
      if (last_we) last_mem[last_wa] <= fill_ff[EW-1:0];
      if (cur_we) cur_mem[cur_wa] <= cur_wd;
      if (stk_we) stack_mem[stk_wa] <= stk_wd;
      head_rd_ff <= first_mem[vrd_a] | tail_unused;
      last_rd_ff <= last_mem[vrd_a];
      cur_rd_ff  <= cur_mem[vrd_a];
      stk_rd_ff  <= stack_mem[stk_ra];
   end

   dts_edge_mem #(.MAX_EDGES(MAX_EDGES), .VW(VW), .EW(EW)) u_edges (
      .clock(clock), .wr_en(e_we), .wr_addr(fill_ff[EW-1:0]), .wr_target(dst_ff),
      .wr_link(ENONE), .lk_en(lk_en), .lk_addr(last_rd_ff), .lk_link(fill_ff),
      .rd_addr(e_ra), .rd_target(e_tgt), .rd_link(e_link));

   assign req_tready = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {2'b00, out_vx_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_drop_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_VCOUNT) ? {25'd0, vcount_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) vcount_ff <= VCOUNT_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_VCOUNT)
         vcount_ff <= csr_pwdata[6:0];
   end

   logic [VI-1:0] top_idx;
   assign top_idx = VI'(depth_ff - DW'(1));

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; drop_in = drop_ff;
      head_ok_in = head_ok_ff; vis_in = vis_ff; depth_in = depth_ff;
      start_in = start_ff; v_in = v_ff; c_in = c_ff; src_in = src_ff;
      dst_in = dst_ff; ptr_in = ptr_ff;
      out_v_in = out_v_ff && !rsp_tready; out_vx_in = out_vx_ff;
      out_last_in = out_last_ff; out_drop_in = out_drop_ff;
      first_we = 1'b0; first_wa = VI'(src_ff); first_wd = fill_ff;
      last_we = 1'b0; last_wa = VI'(src_ff);
      cur_we = 1'b0; cur_wa = v_ff; cur_wd = e_link;
      stk_we = 1'b0; stk_wa = VI'(depth_ff); stk_wd = VW'(start_ff);
      e_we = 1'b0; lk_en = 1'b0; e_ra = c_ff[EW-1:0];
      vrd_a = VI'(src_ff); stk_ra = top_idx;
      unique case (state_ff)
         S_IDLE: begin
            vrd_a = VI'(req_tdata[7:2]);
            if (req_tvalid && req_tready) begin
               src_in = req_tdata[7:2]; dst_in = req_tdata[13:8];
               unique case (req_tdata[1:0])
                  MODE_ADD: begin
                     if ({1'b0, req_tdata[7:2]} < MAXV7 &&
                         {1'b0, req_tdata[13:8]} < MAXV7) begin
                        if (fill_ff >= ENONE) drop_in = 1'b1;
                        else state_in = S_ADD1;
                     end
                  end
                  MODE_RUN: begin ptr_in = '0; state_in = S_SWEEP; end
                  MODE_CLEAR: begin
                     head_ok_in = '0; fill_in = '0; drop_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_ADD1: begin
            // Head and tail reads land; the new edge is written as the list end.
            e_we = 1'b1;
            state_in = S_ADD2;
         end
         S_ADD2: begin
            last_we = 1'b1;
            if (!head_ok_ff[VI'(src_ff)] || head_rd_ff == ENONE) begin
               first_we = 1'b1; head_ok_in[VI'(src_ff)] = 1'b1;
            end else lk_en = 1'b1;
            fill_in = fill_ff + (EW+1)'(1);
            state_in = S_IDLE;
         end
         S_SWEEP: begin
            // Copy heads into cursors and clear marks, one vertex at a time through S_SWEEP and S_CLR.
            vrd_a = ptr_ff;
            state_in = S_CLR;
         end
         S_CLR: begin
            cur_we = 1'b1; cur_wa = ptr_ff;
            cur_wd = head_ok_ff[ptr_ff] ? head_rd_ff : ENONE;
            vis_in[ptr_ff] = 1'b0;
            if (ptr_ff == VI'(MAX_VERTICES - 1)) begin
               start_in = '0; depth_in = '0; state_in = S_START;
            end else begin ptr_in = ptr_ff + VI'(1); state_in = S_SWEEP; end
         end
         S_START: begin
            if (start_ff >= n_eff) begin
               if (out_v_ff && !rsp_tready) state_in = S_START;
               else begin
                  if (out_v_ff) out_last_in = out_last_ff;
                  state_in = S_IDLE;
               end
            end else if (vis_ff[VI'(start_ff)]) start_in = start_ff + 7'd1;
            else begin
               vis_in[VI'(start_ff)] = 1'b1;
               stk_we = 1'b1; stk_wa = '0; stk_wd = VW'(start_ff);
               depth_in = DW'(1);
               start_in = start_ff + 7'd1;
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            state_in = S_NEXT;  // stack top read in flight
         end
         S_NEXT: begin
            v_in = VI'(stk_rd_ff); vrd_a = VI'(stk_rd_ff);
            state_in = S_CUR;
         end
         S_CUR: begin
            c_in = cur_rd_ff; e_ra = cur_rd_ff[EW-1:0];
            state_in = (cur_rd_ff >= ENONE) ? S_EMIT : S_EDGE;
         end
         S_EDGE: begin
            cur_we = 1'b1;
            if (t_ext < n_eff && !vis_ff[VI'(e_tgt)] && depth_ff < DW'(MAX_VERTICES)) begin
               vis_in[VI'(e_tgt)] = 1'b1;
               stk_we = 1'b1; stk_wd = e_tgt;
               depth_in = depth_ff + DW'(1);
               state_in = S_TOP;
            end else state_in = S_NEXT;
            stk_ra = top_idx;
            if (!(t_ext < n_eff && !vis_ff[VI'(e_tgt)] && depth_ff < DW'(MAX_VERTICES)))
               state_in = S_TOP;
         end
         S_EMIT: begin
            if (!out_v_ff || rsp_tready) begin
               out_v_in = 1'b1; out_vx_in = VW'(v_ff); out_drop_in = drop_ff;
               out_last_in = 1'b0;
               depth_in = depth_ff - DW'(1);
               if (depth_ff == DW'(1)) begin
                  state_in = S_START;
                  // Last if no unvisited start vertex remains.
                  out_last_in = 1'b1;
                  for (int i = 0; i < MAX_VERTICES; i++)
                     if (7'(i) >= start_ff && 7'(i) < n_eff && !vis_ff[i])
                        out_last_in = 1'b0;
               end else state_in = S_TOP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; fill_ff <= '0; drop_ff <= 1'b0;
         head_ok_ff <= '0; depth_ff <= '0; out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; drop_ff <= drop_in;
         head_ok_ff <= head_ok_in; depth_ff <= depth_in; out_v_ff <= out_v_in;
      end
      vis_ff <= vis_in; start_ff <= start_in; v_ff <= v_in; c_ff <= c_in;
      src_ff <= src_in; dst_ff <= dst_in; ptr_ff <= ptr_in;
      out_vx_ff <= out_vx_in; out_last_ff <= out_last_in; out_drop_ff <= out_drop_in;
   end
endmodule
`default_nettype wire
